[rtl/core/e2s_pkg.sv]
// Package for the EUC-JP to Shift-JIS stream converter.
// Holds the shared result and state types, byte constants and queue sizing.
// No dependencies.
package e2s_pkg;

  // Byte constants
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  // Row conversion constants
  localparam logic signed [9:0] ROW_BASE  = 10'sh021;
  localparam logic signed [9:0] ROW_OFS   = 10'sh081;
  localparam logic signed [9:0] ROW_LIMIT = 10'sh09F;
  localparam logic signed [9:0] ROW_SKIP  = 10'sh040;

  // Cell conversion constants
  localparam logic signed [9:0] CELL_ODD_OFS  = 10'sh061;
  localparam logic signed [9:0] CELL_LIMIT    = 10'sh07E;
  localparam logic signed [9:0] CELL_EVEN_OFS = 10'sh002;

  // Result queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } res_t;

  // Converter state carried between input bytes
  typedef struct packed {
    logic       lead_pending;
    logic [7:0] held_lead;
    logic       last_was_cr;
  } st_t;

  // Converter output for one input byte
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
    st_t        nxt;
  } conv_t;

endpackage

[rtl/core/e2s_conv.sv]
// Combinational byte converter: one EUC-JP byte plus held state in,
// up to two Shift-JIS results and the next state out. Uses e2s_pkg.
module e2s_conv (
  input  logic [7:0]   byte_in,
  input  e2s_pkg::st_t st,
  output e2s_pkg::conv_t cv
);

  logic signed [9:0] lead_v;
  logic signed [9:0] diff;
  logic signed [9:0] half;
  logic signed [9:0] row_v;
  logic signed [9:0] cell_v;
  logic [7:0]        row_b;
  logic [7:0]        cell_b;

  // Row byte: halve (lead - 0x80 - 0x21) toward zero, offset, skip gap
  always_comb begin
    lead_v = {3'b000, st.held_lead[6:0]};
    diff   = lead_v - e2s_pkg::ROW_BASE;
    half   = (diff + $signed({9'd0, diff[9]})) >>> 1;
    row_v  = half + e2s_pkg::ROW_OFS;
    if (row_v > e2s_pkg::ROW_LIMIT) begin
      row_v = row_v + e2s_pkg::ROW_SKIP;
    end
    row_b = row_v[7:0];
  end

  // Cell byte: parity of the lead picks the rule
  always_comb begin
    if (st.held_lead[0]) begin
      cell_v = {2'b00, byte_in} - e2s_pkg::CELL_ODD_OFS;
      if (cell_v > e2s_pkg::CELL_LIMIT) begin
        cell_v = cell_v + 10'sd1;
      end
    end else begin
      cell_v = {2'b00, byte_in} - e2s_pkg::CELL_EVEN_OFS;
    end
    cell_b = cell_v[7:0];
  end

  // Select results and next state
  always_comb begin
    cv.num = 2'd0;
    cv.r0  = '0;
    cv.r1  = '0;
    cv.nxt = st;
    if (byte_in == e2s_pkg::BYTE_NUL) begin
      // end of string: emit terminator, drop any held lead
      cv.num = 2'd1;
      cv.r0  = '{data: e2s_pkg::BYTE_NUL, run_last: 1'b1, string_end: 1'b1};
      cv.nxt = '0;
    end else if (st.lead_pending) begin
      // trail byte: emit row and cell
      cv.num = 2'd2;
      cv.r0  = '{data: row_b, run_last: 1'b0, string_end: 1'b0};
      cv.r1  = '{data: cell_b, run_last: 1'b1, string_end: 1'b0};
      cv.nxt = '{lead_pending: 1'b0, held_lead: 8'h00,
                 last_was_cr: (byte_in == e2s_pkg::BYTE_CR)};
    end else if (byte_in[7]) begin
      // lead byte: hold it
      cv.nxt = '{lead_pending: 1'b1, held_lead: byte_in, last_was_cr: 1'b0};
    end else if (st.last_was_cr && (byte_in == e2s_pkg::BYTE_LF)) begin
      // drop LF after CR
      cv.nxt.last_was_cr = 1'b0;
    end else begin
      // plain byte passes through
      cv.num = 2'd1;
      cv.r0  = '{data: byte_in, run_last: 1'b1, string_end: 1'b0};
      cv.nxt.last_was_cr = (byte_in == e2s_pkg::BYTE_CR);
    end
  end

endmodule

[rtl/core/e2s_fifo.sv]
// Small result queue: takes up to two results per cycle, delivers one
// unless stalled, straight from queue registers. Uses e2s_pkg.
module e2s_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_num,
  input  e2s_pkg::res_t       push_r0,
  input  e2s_pkg::res_t       push_r1,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_stall,
  output e2s_pkg::res_t       out_res
);

  e2s_pkg::res_t                    mem_r [e2s_pkg::QDEPTH];
  logic [e2s_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [e2s_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [e2s_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [e2s_pkg::QPTR_W-1:0]       wr_ptr_p1;
  logic                             pop;

  // Status toward both sides
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= e2s_pkg::QCNT_W'(e2s_pkg::QDEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + e2s_pkg::QPTR_W'(1);

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + e2s_pkg::QPTR_W'(push_num);
    rd_ptr_nxt = rd_ptr_r + e2s_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + e2s_pkg::QCNT_W'(push_num) - e2s_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write one or two entries
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_ptr_r] <= push_r0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_r1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= e2s_pkg::QCNT_W'(e2s_pkg::QDEPTH))
    else $error("result queue count out of range");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == e2s_pkg::QCNT_W'(e2s_pkg::QDEPTH)) ||
    ((wr_ptr_r - rd_ptr_r) == cnt_r[e2s_pkg::QPTR_W-1:0]))
    else $error("result queue pointers disagree with count");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_num != 2'd0) |-> room2)
    else $error("push into result queue without room");
`endif

endmodule

[rtl/core/euc_jp_to_shift_jis_stream_core.sv]
// EUC-JP to Shift-JIS stream converter, top level.
// Each input byte is registered, then converted into the result queue that
// drives the outputs. Throughput: one input byte per cycle; a trail byte's two
// results drain in turn through a 4-entry result queue, and the input stalls
// when that queue has fewer than two free entries. Synchronous active-low reset
// clears the held lead, the CR flag, the input stage and the queue.
module euc_jp_to_shift_jis_stream_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  logic           in_vld_r;
  logic [7:0]     in_byte_r;
  e2s_pkg::st_t   st_r;
  e2s_pkg::conv_t cv;
  e2s_pkg::res_t  out_res;
  logic           room2;
  logic           fire;
  logic [1:0]     push_num;

  // Process the staged byte when the queue can take two results
  assign fire     = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;
  assign push_num = fire ? cv.num : 2'd0;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  // Converter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= cv.nxt;
    end
  end

  e2s_conv u_conv (
    .byte_in (in_byte_r),
    .st      (st_r),
    .cv      (cv)
  );

  e2s_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push_r0   (cv.r0),
    .push_r1   (cv.r1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte       = out_res.data;
  assign out_run_last   = out_res.run_last;
  assign out_string_end = out_res.string_end;

`ifndef SYNTHESIS
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_byte_r == e2s_pkg::BYTE_NUL)) |=> (st_r == '0))
    else $error("terminator did not clear converter state");

  a_lead_no_cr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.lead_pending |-> (!st_r.last_was_cr && st_r.held_lead[7]))
    else $error("held lead state inconsistent");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !room2) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("staged byte lost while queue full");
`endif

endmodule
